/* hw/rtl/okset_pkg.sv */
package okset_pkg;

   // operation codes on req_opcode
   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_EXISTS = 3'd2;
   localparam logic [2:0] OP_NEXT   = 3'd3;
   localparam logic [2:0] OP_PREV   = 3'd4;

   // result status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_NONE = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic compare_en;
      logic insert_en;
      logic delete_en;
      logic want_next;
      logic want_prev;
   } okset_ctrl_type;

endpackage

/* hw/rtl/okset_cell.sv */
module okset_cell
   import okset_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  okset_ctrl_type      ctrl,
   input  logic signed [31:0]  query_key,
   input  logic signed [31:0]  left_key,
   input  logic                left_valid,
   input  logic                left_lt,
   input  logic                left_gt,
   input  logic signed [31:0]  right_key,
   input  logic                right_valid,
   input  logic                right_lt,
   output logic signed [31:0]  key,
   output logic                valid,
   output logic                lt,
   output logic                eq,
   output logic                gt,
   output logic                pick,
   output logic signed [31:0]  pick_key
);

   logic signed [31:0] key_ff, key_in;
   logic               valid_ff, valid_in;
   logic               lt_ff, lt_in;
   logic               eq_ff, eq_in;
   logic               gt_ff, gt_in;
   logic               next_sel, prev_sel;

   // compare the held key against the query
   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      gt_in = gt_ff;
      if (ctrl.compare_en) begin
         lt_in = valid_ff && (key_ff < query_key);
         eq_in = valid_ff && (key_ff == query_key);
         gt_in = valid_ff && (key_ff > query_key);
      end
   end

   // shift up on insert, down on delete; keys below the query stay put
   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (ctrl.insert_en && !lt_ff) begin
         if (left_lt) begin
            key_in   = query_key;
            valid_in = 1'b1;
         end else begin
            key_in   = left_key;
            valid_in = left_valid;
         end
      end else if (ctrl.delete_en && !lt_ff) begin
         key_in   = right_key;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         key_ff   <= key_in;
         valid_ff <= valid_in;
      end
      lt_ff <= lt_in;
      eq_ff <= eq_in;
      gt_ff <= gt_in;
   end

   // first key above the query, last key below it
   assign next_sel = gt_ff && !left_gt;
   assign prev_sel = lt_ff && !right_lt;

   assign pick     = (ctrl.want_next && next_sel) || (ctrl.want_prev && prev_sel);
   assign pick_key = pick ? key_ff : '0;

   assign key   = key_ff;
   assign valid = valid_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;
   assign gt    = gt_ff;

endmodule

/* hw/rtl/ordered_key_set.sv */
// Ordered set of up to CAPACITY distinct signed 32-bit keys, held sorted in a
// row of cells that all compare against the query at once. Each operation
// (insert, delete, exists, next greater, previous smaller) goes through an
// accept cycle, a compare cycle in which every cell registers its
// less/equal/greater flags, and an apply cycle in which cells shift their keys
// to a neighbor on insert or delete and the answer is selected. busy is high
// for the compare and apply cycles; the result is shown for one cycle on
// rsp_valid, in the cycle in which busy falls, and cannot be held off; busy
// blocks new items. The store is empty after reset with no clearing pass.
module ordered_key_set
   import okset_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_query_key,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_answer_key
);

   localparam logic [1:0] STATE_IDLE  = 2'd0;
   localparam logic [1:0] STATE_CMP   = 2'd1;
   localparam logic [1:0] STATE_APPLY = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [2:0]         op_ff, op_in;
   logic signed [31:0] key_ff, key_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_answer_key_ff, rsp_answer_key_in;

   okset_ctrl_type     ctrl;
   logic               accept;
   logic               hit, full, found;
   logic signed [31:0] found_key;

   logic signed [31:0] cell_key   [CAPACITY];
   logic signed [31:0] cell_pkey  [CAPACITY];
   logic [CAPACITY-1:0] cell_valid, cell_lt, cell_eq, cell_gt, cell_pick;

   assign accept = start && !busy;
   assign busy   = (state_ff != STATE_IDLE);

   // sequencer
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               state_in = STATE_CMP;
               op_in    = req_opcode;
               key_in   = req_query_key;
            end
         end
         STATE_CMP:   state_in = STATE_APPLY;
         STATE_APPLY: state_in = STATE_IDLE;
         default:     state_in = STATE_IDLE;
      endcase
   end

   // reductions over the row
   always_comb begin
      found_key = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         found_key = found_key | cell_pkey[i];
      end
   end
   assign hit   = |cell_eq;
   assign found = |cell_pick;
   assign full  = cell_valid[CAPACITY-1];

   // control broadcast to the cells
   always_comb begin
      ctrl.compare_en = (state_ff == STATE_CMP);
      ctrl.insert_en  = (state_ff == STATE_APPLY) && (op_ff == OP_INSERT) && !hit && !full;
      ctrl.delete_en  = (state_ff == STATE_APPLY) && (op_ff == OP_DELETE) && hit;
      ctrl.want_next  = (op_ff == OP_NEXT);
      ctrl.want_prev  = (op_ff == OP_PREV);
   end

   // result word
   always_comb begin
      rsp_valid_in      = (state_ff == STATE_APPLY);
      rsp_status_in     = STAT_NONE;
      rsp_answer_key_in = '0;
      unique case (op_ff)
         OP_INSERT: rsp_status_in = (hit || !full) ? STAT_OK : STAT_FULL;
         OP_DELETE, OP_EXISTS: rsp_status_in = hit ? STAT_OK : STAT_NONE;
         OP_NEXT, OP_PREV: begin
            rsp_status_in     = found ? STAT_OK : STAT_NONE;
            rsp_answer_key_in = found_key;
         end
         default: rsp_status_in = STAT_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff             <= op_in;
      key_ff            <= key_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_answer_key_ff <= rsp_answer_key_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_answer_key = rsp_answer_key_ff;

   // row of cells, lowest key in cell 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] l_key, r_key;
      logic               l_valid, l_lt, l_gt, r_valid, r_lt;

      if (i == 0) begin : g_first
         assign l_key   = '0;
         assign l_valid = 1'b0;
         assign l_lt    = 1'b1;
         assign l_gt    = 1'b0;
      end else begin : g_mid_l
         assign l_key   = cell_key[i-1];
         assign l_valid = cell_valid[i-1];
         assign l_lt    = cell_lt[i-1];
         assign l_gt    = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign r_key   = '0;
         assign r_valid = 1'b0;
         assign r_lt    = 1'b0;
      end else begin : g_mid_r
         assign r_key   = cell_key[i+1];
         assign r_valid = cell_valid[i+1];
         assign r_lt    = cell_lt[i+1];
      end

      okset_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .query_key   (key_ff),
         .left_key    (l_key),
         .left_valid  (l_valid),
         .left_lt     (l_lt),
         .left_gt     (l_gt),
         .right_key   (r_key),
         .right_valid (r_valid),
         .right_lt    (r_lt),
         .key         (cell_key[i]),
         .valid       (cell_valid[i]),
         .lt          (cell_lt[i]),
         .eq          (cell_eq[i]),
         .gt          (cell_gt[i]),
         .pick        (cell_pick[i]),
         .pick_key    (cell_pkey[i])
      );
   end

`ifndef SYNTHESIS
   // a result only follows an apply cycle
   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == STATE_APPLY)
      else $error("result strobe without apply cycle");

   // a full drop only answers an insert
   a_full_only_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STAT_FULL) |-> op_ff == OP_INSERT)
      else $error("full status on a non-insert");

   // a nonzero answer key comes with a found status
   a_answer_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_answer_key_ff != '0) |-> rsp_status_ff == STAT_OK)
      else $error("answer key without found status");

   // at most one cell offers the answer
   a_one_pick: assert property (@(posedge clock) disable iff (reset)
      state_ff == STATE_APPLY |-> $onehot0(cell_pick))
      else $error("several cells picked");

   // occupied cells stay packed at the low end
   a_packed: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid >> 1) & ~cell_valid) == '0)
      else $error("gap in occupied cells");

   // an accepted item makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after accept");
`endif

endmodule
